// ===== rtl/bpmu_pkg.sv =====
// shared types and constants of the bank page mapping unit
`timescale 1ns / 1ps
`default_nettype none

package bpmu_pkg;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        PORT_STATUS = 2'd0,
        PORT_RAM    = 2'd1,
        PORT_BANK_A = 2'd2,
        PORT_BANK_B = 2'd3
    } t_port;

    typedef enum logic [1:0] {
        CFG_SMALL_MODEL = 2'd0,
        CFG_FLASH_LIMIT = 2'd1,
        CFG_RAM_LIMIT   = 2'd2
    } t_cfg_index;

    localparam logic [7:0] RAM_MARK_SMALL  = 8'h40;
    localparam logic [7:0] RAM_MARK_LARGE  = 8'h80;
    localparam logic [6:0] PAGE_MASK_SMALL = 7'h1F;
    localparam logic [6:0] PAGE_MASK_LARGE = 7'h7F;
    localparam logic [7:0] PAGE_EVEN_MASK  = 8'hFE;

    localparam logic [7:0] FLASH_LIMIT_RESET = 8'd127;
    localparam logic [7:0] RAM_LIMIT_RESET   = 8'd7;

    typedef struct packed {
        logic       small_model;
        logic [7:0] flash_limit;
        logic [7:0] ram_limit;
    } t_cfg;

    // mapping registers as seen after the current access
    typedef struct packed {
        logic       mode_nz;
        logic [7:0] ram_page;
        logic [6:0] a_page;
        logic       a_flash;
        logic [6:0] b_page;
        logic       b_flash;
    } t_bank_state;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] bank1_page;
        logic       bank1_is_flash;
        logic [7:0] bank2_page;
        logic       bank2_is_flash;
        logic [7:0] bank3_page;
        logic       bank3_is_flash;
        logic [3:0] clamp_flags;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/bpmu_access.sv =====
// port access decode: mapping registers and read data
`timescale 1ns / 1ps
`default_nettype none

module bpmu_access (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_en,
    input  wire logic                 i_small_model,
    input  wire logic                 i_op,
    input  wire logic [1:0]           i_port_sel,
    input  wire logic [7:0]           i_write_data,
    input  wire logic [7:0]           i_irq_flags,
    output logic      [7:0]           o_read_data,
    output bpmu_pkg::t_bank_state     o_state
);
    import bpmu_pkg::*;

    logic [7:0] r_mode_byte, n_mode_byte;
    logic [7:0] r_ram_page, n_ram_page;
    logic [6:0] r_a_page, n_a_page;
    logic       r_a_flash, n_a_flash;
    logic [6:0] r_b_page, n_b_page;
    logic       r_b_flash, n_b_flash;

    logic [7:0] ram_mark;
    logic [6:0] page_mask;
    logic       wr_flash;
    logic [6:0] wr_page;

    assign ram_mark  = i_small_model ? RAM_MARK_SMALL : RAM_MARK_LARGE;
    assign page_mask = i_small_model ? PAGE_MASK_SMALL : PAGE_MASK_LARGE;
    assign wr_flash  = ~|(i_write_data & ram_mark);
    assign wr_page   = i_write_data[6:0] & page_mask;

    always_comb begin
        n_mode_byte = r_mode_byte;
        n_ram_page  = r_ram_page;
        n_a_page    = r_a_page;
        n_a_flash   = r_a_flash;
        n_b_page    = r_b_page;
        n_b_flash   = r_b_flash;
        o_read_data = 8'd0;
        if (t_op'(i_op) == OP_WRITE) begin
            case (t_port'(i_port_sel))
                PORT_STATUS: n_mode_byte = i_write_data;
                PORT_RAM:    n_ram_page  = i_write_data;
                PORT_BANK_A: begin
                    n_a_page  = wr_page;
                    n_a_flash = wr_flash;
                end
                default: begin
                    n_b_page  = wr_page;
                    n_b_flash = wr_flash;
                end
            endcase
        end else begin
            case (t_port'(i_port_sel))
                PORT_STATUS: o_read_data = i_irq_flags;
                PORT_RAM:    o_read_data = r_ram_page;
                PORT_BANK_A: o_read_data = {1'b0, r_a_page} | (r_a_flash ? 8'd0 : ram_mark);
                default:     o_read_data = {1'b0, r_b_page} | (r_b_flash ? 8'd0 : ram_mark);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_byte <= 8'd0;
            r_ram_page  <= 8'd0;
            r_a_page    <= 7'd0;
            r_a_flash   <= 1'b1;
            r_b_page    <= 7'd0;
            r_b_flash   <= 1'b1;
        end else if (i_en) begin
            r_mode_byte <= n_mode_byte;
            r_ram_page  <= n_ram_page;
            r_a_page    <= n_a_page;
            r_a_flash   <= n_a_flash;
            r_b_page    <= n_b_page;
            r_b_flash   <= n_b_flash;
        end
    end

    // mapping follows the registers as they stand after this access
    assign o_state.mode_nz  = |n_mode_byte;
    assign o_state.ram_page = n_ram_page;
    assign o_state.a_page   = n_a_page;
    assign o_state.a_flash  = n_a_flash;
    assign o_state.b_page   = n_b_page;
    assign o_state.b_flash  = n_b_flash;

endmodule

`default_nettype wire

// ===== rtl/bpmu_map.sv =====
// bank 1 to 3 page selection and limit clamping
`timescale 1ns / 1ps
`default_nettype none

module bpmu_map (
    input  wire bpmu_pkg::t_bank_state i_state,
    input  wire bpmu_pkg::t_cfg        i_cfg,
    input  wire logic [7:0]            i_read_data,
    output bpmu_pkg::t_result          o_result
);
    import bpmu_pkg::*;

    logic [7:0] pg [1:3];
    logic       fl [1:3];
    logic [7:0] pg_out [1:3];
    logic [3:1] clamp;
    logic [7:0] a_page;

    assign a_page = {1'b0, i_state.a_page};

    always_comb begin
        if (i_state.mode_nz) begin
            pg[1] = a_page & PAGE_EVEN_MASK;
            fl[1] = i_state.a_flash;
            pg[2] = i_cfg.small_model ? a_page : (a_page | 8'd1);
            fl[2] = i_state.a_flash;
            pg[3] = {1'b0, i_state.b_page};
            fl[3] = i_state.b_flash;
        end else begin
            pg[1] = a_page;
            fl[1] = i_state.a_flash;
            pg[2] = {1'b0, i_state.b_page};
            fl[2] = i_state.b_flash;
            pg[3] = i_cfg.small_model ? 8'd0 : i_state.ram_page;
            fl[3] = 1'b0;
        end
    end

    always_comb begin
        for (int i = 1; i <= 3; i++) begin
            logic [7:0] lim;
            lim = fl[i] ? i_cfg.flash_limit : i_cfg.ram_limit;
            clamp[i]  = pg[i] > lim;
            pg_out[i] = clamp[i] ? (pg[i] & lim) : pg[i];
        end
    end

    // bank 0 is flash page 0 and never clamps
    assign o_result.read_data      = i_read_data;
    assign o_result.bank1_page     = pg_out[1];
    assign o_result.bank1_is_flash = fl[1];
    assign o_result.bank2_page     = pg_out[2];
    assign o_result.bank2_is_flash = fl[2];
    assign o_result.bank3_page     = pg_out[3];
    assign o_result.bank3_is_flash = fl[3];
    assign o_result.clamp_flags    = {clamp, 1'b0};

endmodule

`default_nettype wire

// ===== rtl/bank_page_mapping_unit.sv =====
// top level of the bank page mapping unit
// Each port access request (read or write of status/mode, RAM page, bank A or bank B) yields
// one result: the read byte and the clamped pages of banks 1 to 3. A request is held in an
// input register and passes through the decode and mapping logic into a result register, so
// the block takes one request per cycle while results are taken and presents each result from
// there; the two registers together let one new request in while a result waits. Configuration
// writes are taken at once and apply to later requests.
`timescale 1ns / 1ps
`default_nettype none

module bank_page_mapping_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_op,
    input  wire logic [1:0] i_port_sel,
    input  wire logic [7:0] i_write_data,
    input  wire logic [7:0] i_irq_flags,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic      [7:0] o_read_data,
    output logic      [7:0] o_bank1_page,
    output logic            o_bank1_is_flash,
    output logic      [7:0] o_bank2_page,
    output logic            o_bank2_is_flash,
    output logic      [7:0] o_bank3_page,
    output logic            o_bank3_is_flash,
    output logic      [3:0] o_clamp_flags
);
    import bpmu_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic        r_op;
    logic [1:0]  r_port_sel;
    logic [7:0]  r_write_data;
    logic [7:0]  r_irq_flags;
    logic        r_out_valid;
    t_result     r_result;

    logic        advance;
    logic [7:0]  rd_data;
    t_bank_state state;
    t_result     result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.small_model <= 1'b0;
            r_cfg.flash_limit <= FLASH_LIMIT_RESET;
            r_cfg.ram_limit   <= RAM_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SMALL_MODEL: r_cfg.small_model <= i_cfg_data[0];
                CFG_FLASH_LIMIT: r_cfg.flash_limit <= i_cfg_data;
                CFG_RAM_LIMIT:   r_cfg.ram_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the held request moves on when the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op         <= i_op;
            r_port_sel   <= i_port_sel;
            r_write_data <= i_write_data;
            r_irq_flags  <= i_irq_flags;
        end
    end

    bpmu_access u_access (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_small_model (r_cfg.small_model),
        .i_op          (r_op),
        .i_port_sel    (r_port_sel),
        .i_write_data  (r_write_data),
        .i_irq_flags   (r_irq_flags),
        .o_read_data   (rd_data),
        .o_state       (state)
    );

    bpmu_map u_map (
        .i_state     (state),
        .i_cfg       (r_cfg),
        .i_read_data (rd_data),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_result.read_data;
    assign o_bank1_page     = r_result.bank1_page;
    assign o_bank1_is_flash = r_result.bank1_is_flash;
    assign o_bank2_page     = r_result.bank2_page;
    assign o_bank2_is_flash = r_result.bank2_is_flash;
    assign o_bank3_page     = r_result.bank3_page;
    assign o_bank3_is_flash = r_result.bank3_is_flash;
    assign o_clamp_flags    = r_result.clamp_flags;

endmodule

`default_nettype wire

// ===== test/bank_page_mapping_unit_tb.sv =====
// self-checking testbench of the bank page mapping unit
`timescale 1ns / 1ps

module bank_page_mapping_unit_tb;

    import bpmu_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_BLOCK = 69;
    localparam int RESULT_LATENCY  = 2;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_op = 1'b0;
    logic [1:0] i_port_sel = '0;
    logic [7:0] i_write_data = '0;
    logic [7:0] i_irq_flags = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_read_data;
    logic [7:0] o_bank1_page;
    logic       o_bank1_is_flash;
    logic [7:0] o_bank2_page;
    logic       o_bank2_is_flash;
    logic [7:0] o_bank3_page;
    logic       o_bank3_is_flash;
    logic [3:0] o_clamp_flags;

    bank_page_mapping_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_port_sel      (i_port_sel),
        .i_write_data    (i_write_data),
        .i_irq_flags     (i_irq_flags),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_read_data     (o_read_data),
        .o_bank1_page    (o_bank1_page),
        .o_bank1_is_flash(o_bank1_is_flash),
        .o_bank2_page    (o_bank2_page),
        .o_bank2_is_flash(o_bank2_is_flash),
        .o_bank3_page    (o_bank3_page),
        .o_bank3_is_flash(o_bank3_is_flash),
        .o_clamp_flags   (o_clamp_flags)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the mapping registers and the configuration
    logic       sh_small     = 1'b0;
    logic [7:0] sh_flash_lim = FLASH_LIMIT_RESET;
    logic [7:0] sh_ram_lim   = RAM_LIMIT_RESET;
    logic [7:0] sh_mode      = '0;
    logic [7:0] sh_ram_page  = '0;
    logic [6:0] sh_a_page    = '0;
    logic       sh_a_flash   = 1'b1;
    logic [6:0] sh_b_page    = '0;
    logic       sh_b_flash   = 1'b1;

    t_result pending_maps[$];

    int gap_pct     = 0;
    int stall_pct   = 0;
    int err_count   = 0;
    int sent_count  = 0;
    int match_count = 0;
    int cfg_count   = 0;
    int cycle_count = 0;

    function automatic logic [7:0] bank_port_byte(input logic [6:0] page, input logic flash);
        logic [7:0] mark;
        mark = sh_small ? RAM_MARK_SMALL : RAM_MARK_LARGE;
        return flash ? {1'b0, page} : ({1'b0, page} | mark);
    endfunction

    // applies one request to the shadow state and returns the mapping it yields
    function automatic t_result map_access(input t_op op, input t_port port,
                                           input logic [7:0] wd, input logic [7:0] irq);
        t_result    r;
        logic [7:0] mark;
        logic [6:0] pmask;
        logic [7:0] pg [1:3];
        logic       fl [1:3];
        logic [7:0] lim;
        int         i;
        mark  = sh_small ? RAM_MARK_SMALL : RAM_MARK_LARGE;
        pmask = sh_small ? PAGE_MASK_SMALL : PAGE_MASK_LARGE;
        r = '0;
        if (op == OP_WRITE) begin
            case (port)
                PORT_STATUS: sh_mode = wd;
                PORT_RAM:    sh_ram_page = wd;
                PORT_BANK_A: begin
                    sh_a_flash = ((wd & mark) == 8'h00);
                    sh_a_page  = wd[6:0] & pmask;
                end
                default: begin
                    sh_b_flash = ((wd & mark) == 8'h00);
                    sh_b_page  = wd[6:0] & pmask;
                end
            endcase
        end else begin
            case (port)
                PORT_STATUS: r.read_data = irq;
                PORT_RAM:    r.read_data = sh_ram_page;
                PORT_BANK_A: r.read_data = bank_port_byte(sh_a_page, sh_a_flash);
                default:     r.read_data = bank_port_byte(sh_b_page, sh_b_flash);
            endcase
        end
        if (sh_mode != 8'h00) begin
            pg[1] = {1'b0, sh_a_page} & PAGE_EVEN_MASK;
            fl[1] = sh_a_flash;
            pg[2] = sh_small ? {1'b0, sh_a_page} : ({1'b0, sh_a_page} | 8'h01);
            fl[2] = sh_a_flash;
            pg[3] = {1'b0, sh_b_page};
            fl[3] = sh_b_flash;
        end else begin
            pg[1] = {1'b0, sh_a_page};
            fl[1] = sh_a_flash;
            pg[2] = {1'b0, sh_b_page};
            fl[2] = sh_b_flash;
            pg[3] = sh_small ? 8'h00 : sh_ram_page;
            fl[3] = 1'b0;
        end
        for (i = 1; i <= 3; i++) begin
            lim = fl[i] ? sh_flash_lim : sh_ram_lim;
            if (pg[i] > lim) begin
                pg[i] = pg[i] & lim;
                r.clamp_flags[i] = 1'b1;
            end
        end
        r.bank1_page     = pg[1];
        r.bank1_is_flash = fl[1];
        r.bank2_page     = pg[2];
        r.bank2_is_flash = fl[2];
        r.bank3_page     = pg[3];
        r.bank3_is_flash = fl[3];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    // request capture, result checking and configuration tracking
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_maps.size() == 0) begin
                    $error("result with no request outstanding");
                    err_count++;
                end else begin
                    want = pending_maps.pop_front();
                    check_field("read_data", want.read_data, o_read_data);
                    check_field("bank1_page", want.bank1_page, o_bank1_page);
                    check_field("bank1_is_flash", 8'(want.bank1_is_flash),
                                8'(o_bank1_is_flash));
                    check_field("bank2_page", want.bank2_page, o_bank2_page);
                    check_field("bank2_is_flash", 8'(want.bank2_is_flash),
                                8'(o_bank2_is_flash));
                    check_field("bank3_page", want.bank3_page, o_bank3_page);
                    check_field("bank3_is_flash", 8'(want.bank3_is_flash),
                                8'(o_bank3_is_flash));
                    check_field("clamp_flags", 8'(want.clamp_flags), 8'(o_clamp_flags));
                    match_count++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                pending_maps.push_back(map_access(t_op'(i_op), t_port'(i_port_sel),
                                                  i_write_data, i_irq_flags));
            end
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SMALL_MODEL: sh_small = i_cfg_data[0];
                    CFG_FLASH_LIMIT: sh_flash_lim = i_cfg_data;
                    CFG_RAM_LIMIT:   sh_ram_lim = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_maps.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic issue_access(input t_op op, input t_port port,
                                input logic [7:0] wd, input logic [7:0] irq);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_op         = op;
        i_port_sel   = port;
        i_write_data = wd;
        i_irq_flags  = irq;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_maps.size() != 0) @(posedge i_clk);
        repeat (RESULT_LATENCY + 1) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cfg_count++;
    endtask

    // registers as they come out of reset, read under the reset configuration
    task automatic test_reset_state();
        issue_access(OP_READ, PORT_STATUS, 8'h00, 8'hFF);
        issue_access(OP_READ, PORT_STATUS, 8'hFF, 8'h00);
        issue_access(OP_READ, PORT_RAM, 8'h00, 8'h00);
        issue_access(OP_READ, PORT_BANK_A, 8'h00, 8'h00);
    endtask

    task automatic test_large_model_ports();
        issue_access(OP_WRITE, PORT_RAM, 8'hFF, 8'h00);     // ram page above ram limit
        issue_access(OP_WRITE, PORT_BANK_A, 8'hFF, 8'h00);  // ram marker, page 7f clamped
        issue_access(OP_READ, PORT_BANK_A, 8'h00, 8'h00);
        issue_access(OP_WRITE, PORT_BANK_B, 8'h7F, 8'h00);  // flash page at the limit
        issue_access(OP_READ, PORT_BANK_B, 8'h00, 8'h00);
        issue_access(OP_WRITE, PORT_STATUS, 8'h80, 8'h00);  // any nonzero bit picks mode 1
        issue_access(OP_WRITE, PORT_BANK_A, 8'h00, 8'h00);
        issue_access(OP_WRITE, PORT_STATUS, 8'h01, 8'h00);
        issue_access(OP_READ, PORT_STATUS, 8'h00, 8'hA5);
        issue_access(OP_WRITE, PORT_STATUS, 8'h00, 8'h00);
    endtask

    task automatic test_small_model_ports();
        wait_for_results();
        write_register(CFG_SMALL_MODEL, 8'h01);
        // bank b keeps its large-model page after the switch
        issue_access(OP_READ, PORT_BANK_B, 8'h00, 8'h00);
        issue_access(OP_WRITE, PORT_BANK_A, 8'h7F, 8'h00);  // bit 6 marks ram here
        issue_access(OP_READ, PORT_BANK_A, 8'h00, 8'h00);
        issue_access(OP_WRITE, PORT_BANK_B, 8'h80, 8'h00);  // bit 7 is not the marker
        issue_access(OP_WRITE, PORT_RAM, 8'h33, 8'h00);
        issue_access(OP_WRITE, PORT_STATUS, 8'hFF, 8'h00);
        issue_access(OP_WRITE, PORT_BANK_A, 8'h15, 8'h00);
        issue_access(OP_READ, PORT_BANK_B, 8'h00, 8'h00);
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        int         blk;
        int         n;
        logic [7:0] flash_lim;
        logic [7:0] ram_lim;
        t_op        op;
        t_port      port;
        logic [7:0] wd;
        for (blk = 0; blk < 8; blk++) begin
            case (blk / 2)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 65; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 65; end
                default: begin gap_pct = 17; stall_pct = 17; end
            endcase
            case (blk)
                0: begin flash_lim = 8'd127; ram_lim = 8'd7;   end
                1: begin flash_lim = 8'd255; ram_lim = 8'd0;   end
                2: begin flash_lim = 8'd0;   ram_lim = 8'd255; end
                3: begin flash_lim = 8'd31;  ram_lim = 8'd7;   end
                4: begin flash_lim = 8'($urandom); ram_lim = 8'($urandom); end
                5: begin flash_lim = 8'd255; ram_lim = 8'd3;   end
                6: begin flash_lim = 8'd0;   ram_lim = 8'd0;   end
                default: begin
                    flash_lim = 8'($urandom_range(1, 254));
                    ram_lim   = 8'($urandom_range(1, 254));
                end
            endcase
            wait_for_results();
            write_register(CFG_SMALL_MODEL, {7'd0, blk[0]});
            write_register(CFG_FLASH_LIMIT, flash_lim);
            write_register(CFG_RAM_LIMIT, ram_lim);
            for (n = 0; n < ITEMS_PER_BLOCK; n++) begin
                op   = t_op'($urandom_range(1));
                port = t_port'($urandom_range(3));
                wd   = 8'($urandom);
                // keep both mapping modes in play
                if (op == OP_WRITE && port == PORT_STATUS && $urandom_range(1) == 0) begin
                    wd = 8'h00;
                end
                issue_access(op, port, wd, 8'($urandom));
                if (n == ITEMS_PER_BLOCK / 2) begin
                    wait_for_results();
                end
            end
        end
        wait_for_results();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_state();
        test_large_model_ports();
        test_small_model_ports();
        test_random_traffic();
        $display("covered %0d requests and %0d checked results over %0d register writes,",
                 sent_count, match_count, cfg_count);
        $display("both models, both mapping modes, limit extremes and four idle/stall mixes");
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
